// ===== hw/rtl/bilinear_patch_vertex_warp_core_assert.svh =====
// assertion macros for the bilinear patch vertex warp core
// used by the top level only; the bodies are empty when SYNTHESIS is set
`ifndef BILINEAR_PATCH_VERTEX_WARP_CORE_ASSERT_SVH
`define BILINEAR_PATCH_VERTEX_WARP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPW_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPW_ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define BPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/bpw_pkg.sv =====
// shared types, constants and helpers of the bilinear patch vertex warp core
// no dependencies; imported by the config, control, datapath and top level files
`default_nettype none
package bpw_pkg;

	localparam int unsigned POS_BITS_DEF = 20;
	localparam int unsigned OUT_POS_W    = 20;
	localparam int unsigned NUM_STAGES   = 5;
	localparam int unsigned NUM_COMP     = 3;
	localparam int unsigned PADDR_W      = 6;
	localparam int unsigned PDATA_W      = 64;

	localparam logic signed [15:0] ONE_Q12         = 16'sd4096;
	localparam logic signed [15:0] WIDTH_GAIN_RST  = 16'sd4096;
	localparam logic signed [19:0] HEIGHT_GAIN_RST = 20'sd256;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_Y_RANGE = 2'd1,
		STATUS_V_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_CORNER_00   = 3'd0,
		REG_CORNER_01   = 3'd1,
		REG_CORNER_10   = 3'd2,
		REG_CORNER_11   = 3'd3,
		REG_WIDTH_GAIN  = 3'd4,
		REG_HEIGHT_GAIN = 3'd5,
		REG_UV_BAND     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [19:0] z;
		logic signed [19:0] y;
		logic signed [19:0] x;
	} corner_t;

	typedef struct packed {
		corner_t            c00;
		corner_t            c01;
		corner_t            c10;
		corner_t            c11;
		logic signed [15:0] width_gain;
		logic signed [19:0] height_gain;
		logic               remap_en;
		logic signed [15:0] v_start;
		logic signed [15:0] v_end;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] local_x;
		logic signed [15:0] local_y;
		logic signed [15:0] local_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic [31:0]        vertex_color;
	} vertex_in_t;

	typedef struct packed {
		logic signed [19:0] world_x;
		logic signed [19:0] world_y;
		logic signed [19:0] world_z;
		logic signed [15:0] out_u;
		logic signed [15:0] out_v;
		logic [31:0]        out_color;
		status_t            status;
	} vertex_out_t;

	function automatic logic signed [19:0] corner_comp(corner_t cr, logic [1:0] idx);
		logic signed [19:0] res;
		unique case (idx)
			2'd0: res = cr.x;
			2'd1: res = cr.y;
			default: res = cr.z;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpw_stream_if.sv =====
// valid/ready stream channel carrying one payload beat of type T
// depends on nothing; the payload type is given at instantiation
`default_nettype none
interface bpw_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bpw_cfg_regs.sv =====
// apb-style configuration registers of the warp core, 64-bit data, 8-byte stride
// depends on bpw_pkg
`default_nettype none
module bpw_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpw_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpw_pkg::PDATA_W-1:0]   pwdata,
	output logic [bpw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output bpw_pkg::cfg_t                 cfg
);
	import bpw_pkg::*;

	logic [59:0]        c00_q, c01_q, c10_q, c11_q;
	logic signed [15:0] width_gain_q;
	logic signed [19:0] height_gain_q;
	logic [32:0]        uv_band_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c00_q         <= '0;
			c01_q         <= '0;
			c10_q         <= '0;
			c11_q         <= '0;
			width_gain_q  <= WIDTH_GAIN_RST;
			height_gain_q <= HEIGHT_GAIN_RST;
			uv_band_q     <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CORNER_00:   c00_q <= pwdata[59:0];
				REG_CORNER_01:   c01_q <= pwdata[59:0];
				REG_CORNER_10:   c10_q <= pwdata[59:0];
				REG_CORNER_11:   c11_q <= pwdata[59:0];
				REG_WIDTH_GAIN:  width_gain_q <= pwdata[15:0];
				REG_HEIGHT_GAIN: height_gain_q <= pwdata[19:0];
				REG_UV_BAND:     uv_band_q <= pwdata[32:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CORNER_00:   prdata = {4'b0, c00_q};
			REG_CORNER_01:   prdata = {4'b0, c01_q};
			REG_CORNER_10:   prdata = {4'b0, c10_q};
			REG_CORNER_11:   prdata = {4'b0, c11_q};
			REG_WIDTH_GAIN:  prdata = {48'b0, width_gain_q};
			REG_HEIGHT_GAIN: prdata = {44'b0, height_gain_q};
			REG_UV_BAND:     prdata = {31'b0, uv_band_q};
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		cfg.c00         = c00_q;
		cfg.c01         = c01_q;
		cfg.c10         = c10_q;
		cfg.c11         = c11_q;
		cfg.width_gain  = width_gain_q;
		cfg.height_gain = height_gain_q;
		cfg.remap_en    = uv_band_q[32];
		cfg.v_start     = uv_band_q[31:16];
		cfg.v_end       = uv_band_q[15:0];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bpw_pipe_ctrl.sv =====
// valid bits and per-stage load enables of the warp pipeline
// a stage loads when it is empty or the stage after it moves on; depends on bpw_pkg
`default_nettype none
module bpw_pipe_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              out_ready,
	output logic [bpw_pkg::NUM_STAGES-1:0]    valid,
	output logic [bpw_pkg::NUM_STAGES-1:0]    ld
);
	import bpw_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] en;
	logic [NUM_STAGES-1:0] prev_v;

	always_comb begin
		en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign prev_v   = {valid_q[NUM_STAGES-2:0], in_valid};
	assign ld       = en & prev_v;
	assign in_ready = en[0];
	assign valid    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~en) | (prev_v & en);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bpw_warp_datapath.sv =====
// five-stage arithmetic of the warp: gains, edge products, edge points,
// cross-edge blend, round and saturate; payload only, no reset; depends on bpw_pkg
`default_nettype none
module bpw_warp_datapath #(
	parameter int unsigned POS_BITS = bpw_pkg::POS_BITS_DEF
) (
	input  logic                             clk,
	input  logic [bpw_pkg::NUM_STAGES-1:0]   ld,
	input  bpw_pkg::cfg_t                    cfg,
	input  bpw_pkg::vertex_in_t              in_data,
	output bpw_pkg::vertex_out_t             out_data
);
	import bpw_pkg::*;

	localparam int unsigned SAT_W = (POS_BITS < OUT_POS_W) ? POS_BITS : OUT_POS_W;
	localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (SAT_W - 1)) - 32'sd1;
	localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

	// stage 1
	logic               y_bad, v_bad;
	status_t            status_c;
	logic signed [16:0] v_diff;
	logic signed [31:0] s_s1;
	logic signed [35:0] hz_s1;
	logic signed [13:0] ly_s1;
	logic signed [30:0] vprod_s1;
	logic signed [15:0] tv_s1, u_s1;
	logic [31:0]        color_s1;
	status_t            status_s1;

	// stage 2
	logic signed [20:0] cdiff [2][NUM_COMP];
	logic signed [20:0] csum  [2][NUM_COMP];
	logic signed [31:0] vsum, vshift;
	logic signed [15:0] vsat;
	logic signed [52:0] p_s2 [2][NUM_COMP];
	logic signed [35:0] hz_s2;
	logic signed [13:0] ly_s2;
	logic signed [15:0] v_s2, u_s2;
	logic [31:0]        color_s2;
	status_t            status_s2;

	// stage 3
	logic signed [53:0] esum [2][NUM_COMP];
	logic signed [40:0] e_s3 [2][NUM_COMP];
	logic signed [35:0] hz_s3;
	logic signed [13:0] ly_s3;
	logic signed [15:0] v_s3, u_s3;
	logic [31:0]        color_s3;
	status_t            status_s3;

	// stage 4
	logic signed [41:0] ediff [NUM_COMP];
	logic signed [41:0] sum_s4 [NUM_COMP];
	logic signed [55:0] mul_s4 [NUM_COMP];
	logic signed [35:0] hz_s4;
	logic signed [15:0] v_s4, u_s4;
	logic [31:0]        color_s4;
	status_t            status_s4;

	// stage 5
	logic signed [56:0] acc [NUM_COMP];
	logic signed [31:0] shifted [NUM_COMP];
	logic signed [19:0] world [NUM_COMP];
	vertex_out_t        out_s5;

	always_comb begin
		y_bad = (in_data.local_y > ONE_Q12) || (in_data.local_y < -ONE_Q12);
		v_bad = cfg.remap_en && ((in_data.tex_v < 16'sd0) || (in_data.tex_v > ONE_Q12));
		priority if (y_bad) begin
			status_c = STATUS_Y_RANGE;
		end else if (v_bad) begin
			status_c = STATUS_V_RANGE;
		end else begin
			status_c = STATUS_OK;
		end
		v_diff = 17'(cfg.v_end) - 17'(cfg.v_start);
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			s_s1      <= 32'(in_data.local_x) * 32'(cfg.width_gain);
			hz_s1     <= 36'(in_data.local_z) * 36'(cfg.height_gain);
			ly_s1     <= in_data.local_y[13:0];
			// tex_v lies in 0..1 whenever the remapped value is used
			vprod_s1  <= 31'($signed({1'b0, in_data.tex_v[12:0]})) * 31'(v_diff);
			tv_s1     <= in_data.tex_v;
			u_s1      <= in_data.tex_u;
			color_s1  <= in_data.vertex_color;
			status_s1 <= status_c;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int c = 0; c < NUM_COMP; c++) begin
				if (k == 0) begin
					cdiff[k][c] = 21'(corner_comp(cfg.c01, 2'(c)))
						- 21'(corner_comp(cfg.c00, 2'(c)));
					csum[k][c]  = 21'(corner_comp(cfg.c01, 2'(c)))
						+ 21'(corner_comp(cfg.c00, 2'(c)));
				end else begin
					cdiff[k][c] = 21'(corner_comp(cfg.c11, 2'(c)))
						- 21'(corner_comp(cfg.c10, 2'(c)));
					csum[k][c]  = 21'(corner_comp(cfg.c11, 2'(c)))
						+ 21'(corner_comp(cfg.c10, 2'(c)));
				end
			end
		end
		vsum   = (32'(cfg.v_start) <<< 12) + 32'(vprod_s1) + 32'sd128;
		vshift = vsum >>> 8;
		if (vshift > 32'sd32767) begin
			vsat = 16'sd32767;
		end else if (vshift < -32'sd32768) begin
			vsat = -16'sd32768;
		end else begin
			vsat = vshift[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int k = 0; k < 2; k++) begin
				for (int c = 0; c < NUM_COMP; c++) begin
					// (1-s)*a + (1+s)*b = (a+b) + s*(b-a), s in Q24
					p_s2[k][c] <= 53'(s_s1) * 53'(cdiff[k][c]);
				end
			end
			if (status_s1 != STATUS_OK) begin
				v_s2 <= '0;
			end else if (cfg.remap_en) begin
				v_s2 <= vsat;
			end else begin
				v_s2 <= tv_s1;
			end
			hz_s2     <= hz_s1;
			ly_s2     <= ly_s1;
			u_s2      <= u_s1;
			color_s2  <= color_s1;
			status_s2 <= status_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int c = 0; c < NUM_COMP; c++) begin
				esum[k][c] = (54'(csum[k][c]) <<< 24) + 54'(p_s2[k][c]) + 54'sd4096;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int k = 0; k < 2; k++) begin
				for (int c = 0; c < NUM_COMP; c++) begin
					e_s3[k][c] <= esum[k][c][53:13];
				end
			end
			hz_s3     <= hz_s2;
			ly_s3     <= ly_s2;
			v_s3      <= v_s2;
			u_s3      <= u_s2;
			color_s3  <= color_s2;
			status_s3 <= status_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_COMP; c++) begin
			ediff[c] = 42'(e_s3[1][c]) - 42'(e_s3[0][c]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int c = 0; c < NUM_COMP; c++) begin
				sum_s4[c] <= 42'(e_s3[1][c]) + 42'(e_s3[0][c]);
				mul_s4[c] <= 56'(ediff[c]) * 56'(ly_s3);
			end
			hz_s4     <= hz_s3;
			v_s4      <= v_s3;
			u_s4      <= u_s3;
			color_s4  <= color_s3;
			status_s4 <= status_s3;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_COMP; c++) begin
			acc[c] = (57'(sum_s4[c]) <<< 12) + 57'(mul_s4[c]) + (57'sd1 <<< 24);
			// height term only on the vertical component
			if (c == NUM_COMP - 1) begin
				acc[c] = acc[c] + (57'(hz_s4) <<< 13);
			end
			shifted[c] = acc[c][56:25];
			if (shifted[c] > SAT_HI) begin
				world[c] = SAT_HI[19:0];
			end else if (shifted[c] < SAT_LO) begin
				world[c] = SAT_LO[19:0];
			end else begin
				world[c] = shifted[c][19:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			if (status_s4 != STATUS_OK) begin
				out_s5.world_x <= '0;
				out_s5.world_y <= '0;
				out_s5.world_z <= '0;
			end else begin
				out_s5.world_x <= world[0];
				out_s5.world_y <= world[1];
				out_s5.world_z <= world[2];
			end
			out_s5.out_u     <= u_s4;
			out_s5.out_v     <= v_s4;
			out_s5.out_color <= color_s4;
			out_s5.status    <= status_s4;
		end
	end

	assign out_data = out_s5;
endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_patch_vertex_warp_core.sv =====
// bilinear patch vertex warp core: five register stages, one beat per stage
// path: an accepted beat moves through stages s1 to s5 in order; the output is
// valid while it sits in s5, and a stall can hold it in any stage
// throughput: one vertex per cycle unless stalled; a stalled output holds the
// full stages behind it, bubbles still fill; 32x21 edge multipliers set stage depth
// reset: valid bits cleared, registers to corners 0, width 1.0, height 256, remap off
`default_nettype none
`include "bilinear_patch_vertex_warp_core_assert.svh"
module bilinear_patch_vertex_warp_core #(
	parameter int unsigned POS_BITS = bpw_pkg::POS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bpw_stream_if.sink                    vertex_in,
	bpw_stream_if.source                  vertex_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpw_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpw_pkg::PDATA_W-1:0]   pwdata,
	output logic [bpw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bpw_pkg::*;

	cfg_t                  cfg;
	logic [NUM_STAGES-1:0] vld;
	logic [NUM_STAGES-1:0] ld;
	logic                  in_ready;
	vertex_out_t           dp_out;
	logic                  in_beat;
	logic                  err_beat;
	logic                  err_clear;

	bpw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpw_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertex_in.valid),
		.in_ready  (in_ready),
		.out_ready (vertex_out.ready),
		.valid     (vld),
		.ld        (ld)
	);

	bpw_warp_datapath #(
		.POS_BITS (POS_BITS)
	) u_dp (
		.clk      (clk),
		.ld       (ld),
		.cfg      (cfg),
		.in_data  (vertex_in.data),
		.out_data (dp_out)
	);

	assign vertex_in.ready  = in_ready;
	assign vertex_out.valid = vld[NUM_STAGES-1];
	assign vertex_out.data  = dp_out;

	assign in_beat   = vertex_in.valid && vertex_in.ready;
	assign err_beat  = vertex_out.valid && (dp_out.status != STATUS_OK);
	assign err_clear = (dp_out.world_x == '0) && (dp_out.world_y == '0)
		&& (dp_out.world_z == '0) && (dp_out.out_v == '0);

	// an accepted beat always lands in the first stage
	`BPW_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_beat, vld[0], "beat missing in stage 1")
	// an empty pipeline never back-pressures
	`BPW_ASSERT_HOLDS(a_empty_ready, clk, arst_n, (vld == '0) |-> in_ready, "empty pipe not ready")
	// error results carry zero positions and zero v
	`BPW_ASSERT_HOLDS(a_err_zero, clk, arst_n, err_beat |-> err_clear, "error beat not cleared")
endmodule
`default_nettype wire
